// ===== src/skri_pkg.sv =====
// Shared types and constants for the sorted key range index.
// No dependencies; compiled before every other file.
package skri_pkg;

    localparam int MAX_KEYS    = 1024;
    localparam int MAX_ENTRIES = 65536;

    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int KEY_CW   = $clog2(MAX_KEYS + 1);
    localparam int ENT_AW   = $clog2(MAX_ENTRIES);
    localparam int ENT_CW   = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int IDX_W    = 16;
    localparam int RANGE_W  = 17;
    localparam int STATUS_W = 3;
    localparam int ACT_W    = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ORDER     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SEALED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd5;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_END,
        S_READ
    } state_t;

    // one key store word: the key and the entry position where its group starts
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ENT_CW-1:0] start;
    } key_word_t;

    localparam int KEY_WORD_W = $bits(key_word_t);

    typedef struct packed {
        logic              we;
        logic [KEY_AW-1:0] waddr;
        key_word_t         wdata;
        logic [KEY_AW-1:0] raddr;
    } key_ram_req_t;

    typedef struct packed {
        logic              we;
        logic [ENT_AW-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [ENT_AW-1:0] raddr;
    } ent_ram_req_t;

endpackage

// ===== src/skri_if.sv =====
// Request and response channel interfaces (valid/ready).
// Depends on skri_pkg.
interface skri_req_if;
    logic                          valid;
    logic                          ready;
    logic [skri_pkg::ACT_W-1:0]    action;
    logic [skri_pkg::KEY_W-1:0]    key;
    logic [skri_pkg::VAL_W-1:0]    value;
    logic [skri_pkg::IDX_W-1:0]    entry_index;

    modport source (output valid, action, key, value, entry_index, input ready);
    modport sink   (input valid, action, key, value, entry_index, output ready);
endinterface

interface skri_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [skri_pkg::STATUS_W-1:0] status;
    logic [skri_pkg::RANGE_W-1:0]  range_begin;
    logic [skri_pkg::RANGE_W-1:0]  range_end;
    logic [skri_pkg::VAL_W-1:0]    entry_value;

    modport source (output valid, status, range_begin, range_end, entry_value, input ready);
    modport sink   (input valid, status, range_begin, range_end, entry_value, output ready);
endinterface

// ===== src/skri_ram.sv =====
// Generic simple dual-port synchronous RAM with registered read.
// No package dependencies.
module skri_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/skri_ctrl.sv =====
// Sequencer: insert/finish bookkeeping, binary search over the key store,
// entry reads and the response register. Depends on skri_pkg, skri_if.
module skri_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    skri_req_if.sink                req,
    skri_rsp_if.source              rsp,
    output skri_pkg::key_ram_req_t  key_req,
    input  skri_pkg::key_word_t     key_rdata,
    output skri_pkg::ent_ram_req_t  ent_req,
    input  logic [skri_pkg::VAL_W-1:0] ent_rdata
);

    skri_pkg::state_t state_reg, state_next;

    logic [skri_pkg::KEY_CW-1:0] lo_reg, lo_next;
    logic [skri_pkg::KEY_CW-1:0] hi_reg, hi_next;
    logic [skri_pkg::KEY_CW-1:0] key_count_reg, key_count_next;
    logic [skri_pkg::ENT_CW-1:0] entry_count_reg, entry_count_next;
    logic [skri_pkg::KEY_W-1:0]  last_key_reg, last_key_next;
    logic                        have_key_reg, have_key_next;
    logic                        sealed_reg, sealed_next;
    logic [skri_pkg::KEY_W-1:0]  qkey_reg, qkey_next;
    logic [skri_pkg::ENT_CW-1:0] begin_reg, begin_next;

    logic                          rsp_valid_reg, rsp_valid_next;
    logic [skri_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [skri_pkg::RANGE_W-1:0]  rbegin_reg, rbegin_next;
    logic [skri_pkg::RANGE_W-1:0]  rend_reg, rend_next;
    logic [skri_pkg::VAL_W-1:0]    evalue_reg, evalue_next;

    logic                          in_ready;
    logic                          acc;
    logic                          load_out;
    logic                          fresh;
    logic [skri_pkg::STATUS_W-1:0] ins_status;
    logic [skri_pkg::KEY_CW-1:0]   mid_cur;
    logic [skri_pkg::KEY_CW-1:0]   mid_nxt;
    logic                          found;
    logic                          force_raddr;
    logic [skri_pkg::KEY_CW-1:0]   lo_plus1;

    assign in_ready = (state_reg == skri_pkg::S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign acc      = req.valid && in_ready;
    assign req.ready = in_ready;

    assign mid_cur  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_plus1 = lo_reg + skri_pkg::KEY_CW'(1);
    assign found    = (lo_reg < key_count_reg) && (key_rdata.key == qkey_reg);

    // insert checks, in priority order
    always_comb
    begin
        fresh = !have_key_reg || (req.key != last_key_reg);
        if (sealed_reg)
        begin
            ins_status = skri_pkg::ST_SEALED;
        end
        else if (have_key_reg && (req.key < last_key_reg))
        begin
            ins_status = skri_pkg::ST_ORDER;
        end
        else if (fresh && (key_count_reg == skri_pkg::KEY_CW'(skri_pkg::MAX_KEYS)))
        begin
            ins_status = skri_pkg::ST_FULL;
        end
        else if (entry_count_reg == skri_pkg::ENT_CW'(skri_pkg::MAX_ENTRIES))
        begin
            ins_status = skri_pkg::ST_FULL;
        end
        else
        begin
            ins_status = skri_pkg::ST_OK;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        key_count_next   = key_count_reg;
        entry_count_next = entry_count_reg;
        last_key_next    = last_key_reg;
        have_key_next    = have_key_reg;
        sealed_next      = sealed_reg;
        qkey_next        = qkey_reg;
        begin_next       = begin_reg;
        load_out         = 1'b0;
        status_next      = skri_pkg::ST_OK;
        rbegin_next      = '0;
        rend_next        = '0;
        evalue_next      = '0;
        force_raddr      = 1'b0;

        key_req.we    = 1'b0;
        key_req.waddr = key_count_reg[skri_pkg::KEY_AW-1:0];
        key_req.wdata.key   = req.key;
        key_req.wdata.start = entry_count_reg;
        ent_req.we    = 1'b0;
        ent_req.waddr = entry_count_reg[skri_pkg::ENT_AW-1:0];
        ent_req.wdata = req.value;
        ent_req.raddr = skri_pkg::ENT_AW'(req.entry_index);

        case (state_reg)
            skri_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    case (skri_pkg::action_t'(req.action))
                        skri_pkg::ACT_INSERT:
                        begin
                            load_out    = 1'b1;
                            status_next = ins_status;
                            if (ins_status == skri_pkg::ST_OK)
                            begin
                                ent_req.we       = 1'b1;
                                entry_count_next = entry_count_reg + skri_pkg::ENT_CW'(1);
                                if (fresh)
                                begin
                                    key_req.we     = 1'b1;
                                    key_count_next = key_count_reg + skri_pkg::KEY_CW'(1);
                                    last_key_next  = req.key;
                                    have_key_next  = 1'b1;
                                end
                            end
                        end
                        skri_pkg::ACT_FINISH:
                        begin
                            sealed_next = 1'b1;
                            load_out    = 1'b1;
                        end
                        skri_pkg::ACT_QUERY:
                        begin
                            qkey_next  = req.key;
                            lo_next    = '0;
                            hi_next    = key_count_reg;
                            state_next = skri_pkg::S_SEARCH;
                        end
                        skri_pkg::ACT_READ:
                        begin
                            if (skri_pkg::ENT_CW'(req.entry_index) < entry_count_reg)
                            begin
                                state_next = skri_pkg::S_READ;
                            end
                            else
                            begin
                                load_out    = 1'b1;
                                status_next = skri_pkg::ST_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            skri_pkg::S_SEARCH:
            begin
                // read data holds key_store[mid of lo/hi], or key_store[lo] once they meet
                if (lo_reg < hi_reg)
                begin
                    if (key_rdata.key < qkey_reg)
                    begin
                        lo_next = mid_cur + skri_pkg::KEY_CW'(1);
                    end
                    else
                    begin
                        hi_next = mid_cur;
                    end
                end
                else if (!found)
                begin
                    load_out    = 1'b1;
                    status_next = skri_pkg::ST_NOT_FOUND;
                    state_next  = skri_pkg::S_IDLE;
                end
                else if (lo_plus1 < key_count_reg)
                begin
                    begin_next  = key_rdata.start;
                    force_raddr = 1'b1;
                    state_next  = skri_pkg::S_END;
                end
                else
                begin
                    load_out    = 1'b1;
                    rbegin_next = skri_pkg::RANGE_W'(key_rdata.start);
                    rend_next   = skri_pkg::RANGE_W'(entry_count_reg);
                    state_next  = skri_pkg::S_IDLE;
                end
            end
            skri_pkg::S_END:
            begin
                load_out    = 1'b1;
                rbegin_next = skri_pkg::RANGE_W'(begin_reg);
                rend_next   = skri_pkg::RANGE_W'(key_rdata.start);
                state_next  = skri_pkg::S_IDLE;
            end
            skri_pkg::S_READ:
            begin
                load_out    = 1'b1;
                evalue_next = ent_rdata;
                state_next  = skri_pkg::S_IDLE;
            end
            default:
            begin
                state_next = skri_pkg::S_IDLE;
            end
        endcase

        // probe address follows the next search window
        mid_nxt = lo_next + ((hi_next - lo_next) >> 1);
        if (force_raddr)
        begin
            key_req.raddr = lo_plus1[skri_pkg::KEY_AW-1:0];
        end
        else
        begin
            key_req.raddr = mid_nxt[skri_pkg::KEY_AW-1:0];
        end

        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= skri_pkg::S_IDLE;
            key_count_reg   <= '0;
            entry_count_reg <= '0;
            last_key_reg    <= '0;
            have_key_reg    <= 1'b0;
            sealed_reg      <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            key_count_reg   <= key_count_next;
            entry_count_reg <= entry_count_next;
            last_key_reg    <= last_key_next;
            have_key_reg    <= have_key_next;
            sealed_reg      <= sealed_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        qkey_reg  <= qkey_next;
        begin_reg <= begin_next;
        if (load_out)
        begin
            status_reg <= status_next;
            rbegin_reg <= rbegin_next;
            rend_reg   <= rend_next;
            evalue_reg <= evalue_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.range_begin = rbegin_reg;
    assign rsp.range_end   = rend_reg;
    assign rsp.entry_value = evalue_reg;

endmodule

// ===== src/sorted_key_range_index_top.sv =====
// Top level of the sorted key range index: sequencer plus key and entry stores.
// Depends on skri_pkg, skri_if, skri_ram, skri_ctrl.
//
// Two-level key-to-values index in compressed sparse row form. Each request
// carries an action: insert (key, value), finish, query (key) or read
// (entry_index); each request gives exactly one response, in request order,
// through a response register, so the next request is taken while a finished
// response still waits as long as it is consumed in the same cycle. Inserts
// must come in non-decreasing key order; a new key is appended to the key
// store (1024 words) with the position where its group starts, and every
// value is appended to the entry store (65536 words). Out-of-order keys, full
// stores, inserts after finish and reads beyond the entry count are reported
// in status and store nothing. Steps per request: insert and finish are
// answered directly; read does one entry store read; a query issues the first
// probe, then runs the binary search probes, at most ceil(log2(keys + 1))
// probes, then checks the hit and, unless the hit is the last key, fetches the
// next group's start. The query time is set by the single read port of the key
// store, probed once per cycle. Both stores are uninitialised after reset and
// need no clearing pass: only positions below the running counts are ever used.
// A query before finish is fine; the end of the last group comes from the
// running entry count.
module sorted_key_range_index_top (
    input  logic       clk,
    input  logic       rst_n,
    skri_req_if.sink   req,
    skri_rsp_if.source rsp
);

    skri_pkg::key_ram_req_t        key_req;
    skri_pkg::key_word_t           key_rdata;
    skri_pkg::ent_ram_req_t        ent_req;
    logic [skri_pkg::VAL_W-1:0]    ent_rdata;

    skri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .key_req   (key_req),
        .key_rdata (key_rdata),
        .ent_req   (ent_req),
        .ent_rdata (ent_rdata)
    );

    // key store: key and group start in one word
    skri_ram #(
        .WIDTH (skri_pkg::KEY_WORD_W),
        .DEPTH (skri_pkg::MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_req.we),
        .waddr (key_req.waddr),
        .wdata (key_req.wdata),
        .raddr (key_req.raddr),
        .rdata (key_rdata)
    );

    // entry store: values in insert order
    skri_ram #(
        .WIDTH (skri_pkg::VAL_W),
        .DEPTH (skri_pkg::MAX_ENTRIES)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_req.we),
        .waddr (ent_req.waddr),
        .wdata (ent_req.wdata),
        .raddr (ent_req.raddr),
        .rdata (ent_rdata)
    );

endmodule

// ===== src/skri_checker.sv =====
// Port-level checks for the sorted key range index, bound to the top level.
// Depends on skri_pkg and sorted_key_range_index_top.
module skri_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [skri_pkg::ACT_W-1:0]    req_action,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [skri_pkg::STATUS_W-1:0] rsp_status,
    input logic [skri_pkg::RANGE_W-1:0]  rsp_range_begin,
    input logic [skri_pkg::RANGE_W-1:0]  rsp_range_end,
    input logic [skri_pkg::VAL_W-1:0]    rsp_entry_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_range_begin) && $stable(rsp_range_end)
            && $stable(rsp_entry_value))
        else $error("response changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != skri_pkg::ST_OK) |->
            (rsp_range_begin == '0) && (rsp_range_end == '0) && (rsp_entry_value == '0))
        else $error("failed response carries data");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_range_begin <= rsp_range_end)
        else $error("range begin past range end");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == skri_pkg::ACT_QUERY) |=> !req_ready)
        else $error("request taken during a query search");

endmodule

bind sorted_key_range_index_top skri_checker u_skri_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_action      (req.action),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_range_begin (rsp.range_begin),
    .rsp_range_end   (rsp.range_end),
    .rsp_entry_value (rsp.entry_value)
);

// ===== test/tb_sorted_key_range_index_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sorted_key_range_index_top: directed, random and store-filling
// requests, each predicted by an in-bench model of the index. Depends on skri_pkg, skri_if.
module tb_sorted_key_range_index_top;
    import skri_pkg::*;

    localparam logic [KEY_W-1:0] KEY_MAX   = '1;
    // random-phase keys stay below this so the fill keys can sit at the top of the range
    localparam logic [KEY_W-1:0] KEY_CAP   = 64'h8000_0000_0000_0000;
    // fill key for slot k is FILL_BASE + k, so the last slot holds KEY_MAX - 1
    localparam logic [KEY_W-1:0] FILL_BASE = KEY_MAX - 64'(MAX_KEYS);
    localparam int RANDOM_REQUESTS = 250;
    localparam int TAIL_REQUESTS   = 80;
    // about 1300 requests; the limit is well clear of a correct run
    localparam int CYCLE_LIMIT     = 400_000;
    localparam int SETTLE_CYCLES   = 50;

    // receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    typedef struct {
        action_t             act;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic [IDX_W-1:0]    entry_index;
    } index_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [RANGE_W-1:0]  range_begin;
        logic [RANGE_W-1:0]  range_end;
        logic [VAL_W-1:0]    entry_value;
    } index_response_t;

    logic clk;
    logic rst_n;

    skri_req_if req_ch ();
    skri_rsp_if rsp_ch ();

    sorted_key_range_index_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the index, advanced once per accepted request
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]  shadow_keys   [MAX_KEYS];
    logic [ENT_CW-1:0] shadow_starts [MAX_KEYS];
    logic [VAL_W-1:0]  shadow_values [MAX_ENTRIES];
    logic [KEY_W-1:0]  shadow_last_key    = '0;
    bit                shadow_have_key    = 1'b0;
    bit                shadow_sealed      = 1'b0;
    int                shadow_key_count   = 0;
    int                shadow_entry_count = 0;

    index_request_t  pending_requests   [$];
    index_response_t expected_responses [$];

    // stimulus shaping only: keys and entry count as the generator intends them
    logic [KEY_W-1:0] gen_keys [$];
    logic [KEY_W-1:0] gen_cursor  = '0;
    int               gen_entries = 0;

    int errors      = 0;
    int cycle_count = 0;
    bit req_taken   = 1'b0;
    int gap_left    = 0;
    int burst_left  = 1;
    int rx_mode     = RX_FREE;
    int rx_span     = 0;

    // Works out the response to one request and applies its effect on the shadow index.
    function automatic index_response_t predict_response(index_request_t r);
        index_response_t res;
        bit              fresh;
        int              lo;
        int              hi;
        int              mid;
        res = '{status: ST_OK, range_begin: '0, range_end: '0, entry_value: '0};
        case (r.act)
            ACT_INSERT:
            begin
                fresh = !shadow_have_key || r.key != shadow_last_key;
                // priority: sealed, then order, then either store full
                if (shadow_sealed)
                    res.status = ST_SEALED;
                else if (shadow_have_key && r.key < shadow_last_key)
                    res.status = ST_ORDER;
                else if ((fresh && shadow_key_count >= MAX_KEYS) ||
                         shadow_entry_count >= MAX_ENTRIES)
                    res.status = ST_FULL;
                else
                begin
                    if (fresh)
                    begin
                        shadow_keys[shadow_key_count]   = r.key;
                        shadow_starts[shadow_key_count] = ENT_CW'(shadow_entry_count);
                        shadow_key_count++;
                        shadow_last_key = r.key;
                        shadow_have_key = 1'b1;
                    end
                    shadow_values[shadow_entry_count] = r.value;
                    shadow_entry_count++;
                end
            end
            ACT_FINISH:
                shadow_sealed = 1'b1;
            ACT_QUERY:
            begin
                // lower-bound search over the stored keys
                lo = 0;
                hi = shadow_key_count;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_keys[mid] < r.key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo >= shadow_key_count || shadow_keys[lo] != r.key)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.range_begin = RANGE_W'(shadow_starts[lo]);
                    // last group ends at the running entry count, sealed or not
                    res.range_end = (lo + 1 < shadow_key_count) ?
                                    RANGE_W'(shadow_starts[lo + 1]) :
                                    RANGE_W'(shadow_entry_count);
                end
            end
            default:
            begin
                if (int'(r.entry_index) < shadow_entry_count)
                    res.entry_value = shadow_values[r.entry_index];
                else
                    res.status = ST_BAD_INDEX;
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_request(action_t act, logic [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] value, logic [IDX_W-1:0] idx);
        index_request_t item;
        item = '{act, key, value, idx};
        pending_requests.insert(pending_requests.size(), item);
    endtask

    // Insert request plus generator bookkeeping; only meaningful before the stores fill.
    task automatic queue_insert(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        queue_request(ACT_INSERT, key, value, 16'($urandom));
        if (gen_keys.size() == 0 || key >= gen_cursor)
        begin
            if (gen_keys.size() == 0 || key != gen_cursor)
                gen_keys.insert(gen_keys.size(), key);
            gen_cursor = key;
            gen_entries++;
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_responses.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock and run-length guard
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: acceptance at the rising edge, next request at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
            expected_responses.insert(expected_responses.size(),
                                      predict_response(pending_requests.pop_front()));
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_taken)
        begin
            // current request gone (or none): either sit out a gap or present the next one
            if (gap_left > 0 || pending_requests.size() == 0)
            begin
                req_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                req_ch.valid       <= 1'b1;
                req_ch.action      <= pending_requests[0].act;
                req_ch.key         <= pending_requests[0].key;
                req_ch.value       <= pending_requests[0].value;
                req_ch.entry_index <= pending_requests[0].entry_index;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // mostly short bursts, now and then a long one with no idling at all
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256) :
                                                               $urandom_range(1, 16);
                    if ($urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(8, 30);
                    else
                        gap_left = $urandom_range(1, 4);
                end
            end
        end
    end

    // Receiver back-pressure: stretches of free flow, random stalls and a periodic stall.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rx_span == 0)
            begin
                rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
                rx_span = $urandom_range(8, 96);
            end
            rx_span--;
            case (rx_mode)
                RX_FREE:   rsp_ch.ready <= 1'b1;
                RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default:   rsp_ch.ready <= ((rx_span % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every response against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        index_response_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $display({"%0t: unexpected response: expected none, ",
                          "got status %0d begin %0h end %0h value %0h"},
                         $time, rsp_ch.status, rsp_ch.range_begin, rsp_ch.range_end,
                         rsp_ch.entry_value);
                errors++;
            end
            else
            begin
                want = expected_responses.pop_front();
                check_field("status",      want.status,      rsp_ch.status);
                check_field("range_begin", want.range_begin, rsp_ch.range_begin);
                check_field("range_end",   want.range_end,   rsp_ch.range_end);
                check_field("entry_value", want.entry_value, rsp_ch.entry_value);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [KEY_W-1:0] stride;
        int               pick;
        int               base_keys;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_INSERT;
        req_ch.key         = '0;
        req_ch.value       = '0;
        req_ch.entry_index = '0;
        rsp_ch.ready       = 1'b0;
        repeat (5) @(posedge clk);
        #2 rst_n = 1'b1;

        // Directed: empty index, key zero as first key, repeated key, out-of-order key,
        // hits on first and last group before finish, misses between and above.
        queue_request(ACT_QUERY, '0, '0, '0);
        queue_request(ACT_QUERY, KEY_MAX, KEY_MAX, '1);
        queue_request(ACT_READ, '0, '0, '0);
        queue_insert(64'd0, 64'd0);
        queue_insert(64'd0, KEY_MAX);
        queue_request(ACT_QUERY, 64'd0, '0, '0);
        queue_request(ACT_READ, '0, '0, 16'd1);
        queue_request(ACT_READ, '0, '0, 16'd2);
        queue_request(ACT_READ, '0, '0, 16'hFFFF);
        queue_insert(64'd100, 64'hA5A5_A5A5_A5A5_A5A5);
        queue_insert(64'd99, 64'h5A5A_5A5A_5A5A_5A5A);
        queue_insert(64'd100, rand64());
        queue_request(ACT_QUERY, 64'd100, '0, '0);
        queue_request(ACT_QUERY, 64'd0, '0, '0);
        queue_request(ACT_QUERY, 64'd50, '0, '0);
        queue_request(ACT_QUERY, 64'd101, '0, '0);
        queue_insert(64'h0000_0100_0000_0000, rand64());
        queue_request(ACT_QUERY, 64'h0000_0100_0000_0000, '0, '0);
        queue_request(ACT_READ, '0, '0, 16'd3);
        queue_request(ACT_READ, '0, '0, 16'd4);

        // Random: mainly well-formed ascending inserts mixed with queries and reads,
        // plus a few out-of-order keys and out-of-range reads.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stride = '0;
                    2, 3:    stride = 64'($urandom_range(1, 16));
                    default: stride = rand64() >> $urandom_range(16, 40);
                endcase
                if (gen_cursor + stride >= KEY_CAP)
                    stride = '0;
                queue_insert(gen_cursor + stride, rand64());
            end
            else if (pick < 55)
                queue_insert(gen_cursor - 1 - (rand64() % gen_cursor), rand64());
            else if (pick < 75)
                queue_request(ACT_QUERY, gen_keys[$urandom_range(0, gen_keys.size() - 1)],
                              rand64(), 16'($urandom));
            else if (pick < 82)
            begin
                case ($urandom_range(0, 2))
                    0:       stride = rand64();
                    1:       stride = gen_cursor + 1;
                    default: stride = gen_keys[$urandom_range(0, gen_keys.size() - 1)] + 1;
                endcase
                queue_request(ACT_QUERY, stride, rand64(), 16'($urandom));
            end
            else if (pick < 94)
                queue_request(ACT_READ, rand64(), rand64(),
                              16'($urandom_range(0, gen_entries - 1)));
            else
                queue_request(ACT_READ, rand64(), rand64(), 16'($urandom));
        end
        wait_drained();

        // Fill: top up the key store with keys near the top of the range, then probe
        // the full key store, the last group and both ends of the entry range.
        base_keys = shadow_key_count;
        for (int k = base_keys; k < MAX_KEYS; k++)
        begin
            queue_request(ACT_INSERT, FILL_BASE + 64'(k), rand64(), 16'($urandom));
            if ($urandom_range(0, 63) == 0)
                queue_request(ACT_QUERY, FILL_BASE + 64'($urandom_range(base_keys, k)),
                              '0, '0);
        end
        queue_request(ACT_INSERT, KEY_MAX, rand64(), '0);          // key store full
        queue_request(ACT_INSERT, KEY_MAX - 1, rand64(), '0);      // last group still grows
        queue_request(ACT_INSERT, 64'd0, rand64(), '0);            // order beats full
        queue_request(ACT_QUERY, KEY_MAX - 1, '0, '0);
        queue_request(ACT_QUERY, FILL_BASE + 64'(base_keys), '0, '0);
        queue_request(ACT_READ, '0, '0, 16'hFFFF);
        queue_request(ACT_READ, '0, '0, 16'd0);

        // Seal, seal again, then inserts are refused while queries and reads still work.
        queue_request(ACT_FINISH, rand64(), rand64(), 16'($urandom));
        queue_request(ACT_FINISH, '0, '0, '0);
        queue_request(ACT_INSERT, KEY_MAX, rand64(), '0);
        queue_request(ACT_QUERY, KEY_MAX - 1, '0, '0);
        queue_request(ACT_QUERY, 64'd0, '0, '0);
        for (int i = 0; i < TAIL_REQUESTS; i++)
        begin
            case ($urandom_range(0, 5))
                0:  queue_request(ACT_INSERT, rand64(), rand64(), 16'($urandom));
                1:  queue_request(ACT_FINISH, rand64(), rand64(), 16'($urandom));
                2:  queue_request(ACT_QUERY, gen_keys[$urandom_range(0, gen_keys.size() - 1)],
                                  rand64(), 16'($urandom));
                3:  queue_request(ACT_QUERY, FILL_BASE + 64'($urandom_range(0, MAX_KEYS - 1)),
                                  rand64(), 16'($urandom));
                4:  queue_request(ACT_QUERY, rand64(), rand64(), 16'($urandom));
                default: queue_request(ACT_READ, rand64(), rand64(), 16'($urandom));
            endcase
        end
        wait_drained();

        // let any stray late response show up before judging
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sorted_key_range_index_top.f =====
src/skri_pkg.sv
src/skri_if.sv
src/skri_ram.sv
src/skri_ctrl.sv
src/sorted_key_range_index_top.sv
src/skri_checker.sv
test/tb_sorted_key_range_index_top.sv
